// ===== rtl/core/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int SLOT_BITS  = $clog2(MAX_BLOCKS);
    localparam int LINK_BITS  = SLOT_BITS + 1;
    localparam int ADDR_BITS  = 20;
    localparam int SIZE_BITS  = 20;
    localparam int HDR_BYTES  = 24;

    localparam logic [LINK_BITS-1:0] NULL_SLOT = LINK_BITS'(MAX_BLOCKS);
    localparam logic [ADDR_BITS-1:0] LIMIT_RST = {ADDR_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    // One slot record as stored in the slot memory.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
        logic [LINK_BITS-1:0] link;
    } t_slot_rec;

endpackage

// ===== rtl/core/ffba_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/first_fit_block_allocator_unit.sv =====
// First-fit block allocator: free/used list walker over a slot memory.
// Flow from the accepting edge: release-all, unknown kinds and frees with a null address
// or an empty used list go straight to ST_RESP. An allocate walks the free list in ST_CHECK
// (0..64 entries, one per cycle), then reuses a block via ST_LINK or grows the heap in ST_GROW;
// a free walks the used list, then takes ST_LINK if found. One request at a time.
// Reset (synchronous, active low) empties both lists, clears heap top and slot count.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,     // heap_limit
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // [19:0] request_size, [39:20] data_address
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [19:0] result_address, [20] done_ok, rest zero
);

    localparam int RW = $bits(ffba_pkg::t_slot_rec);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LINK,
        ST_GROW,
        ST_RESP
    } t_state;

    t_state r_state;

    logic [ffba_pkg::LINK_BITS-1:0] r_free_head;
    logic [ffba_pkg::LINK_BITS-1:0] r_used_head;
    logic [ffba_pkg::ADDR_BITS-1:0] r_heap_top;
    logic [ffba_pkg::LINK_BITS-1:0] r_slots_in_use;
    logic [ffba_pkg::ADDR_BITS-1:0] r_heap_limit;

    logic                           r_is_alloc;
    logic [ffba_pkg::SIZE_BITS-1:0] r_req;
    logic [ffba_pkg::ADDR_BITS-1:0] r_addr;
    logic [ffba_pkg::SLOT_BITS-1:0] r_cur;
    logic [ffba_pkg::SLOT_BITS-1:0] r_prev;
    logic                           r_prev_null;
    logic [ffba_pkg::SLOT_BITS-1:0] r_steps;
    ffba_pkg::t_slot_rec            r_prev_rec;
    ffba_pkg::t_slot_rec            r_rec;

    logic [ffba_pkg::ADDR_BITS-1:0] r_res_addr;
    logic                           r_res_ok;
    logic                           r_m_valid;
    logic [ffba_pkg::ADDR_BITS-1:0] r_m_addr;
    logic                           r_m_ok;

    ffba_pkg::t_kind                in_kind;
    logic [ffba_pkg::SIZE_BITS-1:0] in_req;
    logic [ffba_pkg::ADDR_BITS-1:0] in_addr;
    logic [ffba_pkg::LINK_BITS-1:0] in_head;
    logic                           s_beat;

    ffba_pkg::t_slot_rec            rec;
    logic [RW-1:0]                  ram_rdata;
    logic                           ram_we;
    logic [ffba_pkg::SLOT_BITS-1:0] ram_waddr;
    ffba_pkg::t_slot_rec            ram_wrec;
    logic [ffba_pkg::SLOT_BITS-1:0] ram_raddr;

    logic                           hit;
    logic                           walk_end;
    logic [ffba_pkg::ADDR_BITS:0]   start_hdr;
    logic [ffba_pkg::ADDR_BITS+1:0] need;
    logic                           grow_fail;
    logic [ffba_pkg::ADDR_BITS:0]   top_hdr;

    function automatic logic [ffba_pkg::ADDR_BITS-1:0] start_hdr_of(
        input logic [ffba_pkg::ADDR_BITS-1:0] start
    );
        logic [ffba_pkg::ADDR_BITS:0] sum;
        sum = {1'b0, start} + (ffba_pkg::ADDR_BITS+1)'(ffba_pkg::HDR_BYTES);
        return sum[ffba_pkg::ADDR_BITS-1:0];
    endfunction

    assign in_kind = ffba_pkg::t_kind'(i_s_axis_tuser);
    assign in_req  = i_s_axis_tdata[ffba_pkg::SIZE_BITS-1:0];
    assign in_addr = i_s_axis_tdata[ffba_pkg::SIZE_BITS +: ffba_pkg::ADDR_BITS];
    assign in_head = (in_kind == ffba_pkg::KIND_FREE) ? r_used_head : r_free_head;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_beat          = i_s_axis_tvalid && o_s_axis_tready;

    assign rec = ffba_pkg::t_slot_rec'(ram_rdata);

    assign start_hdr = {1'b0, rec.start} + (ffba_pkg::ADDR_BITS+1)'(ffba_pkg::HDR_BYTES);
    assign hit       = r_is_alloc ? (rec.size >= r_req) : (start_hdr == {1'b0, r_addr});
    assign walk_end  = (rec.link >= ffba_pkg::NULL_SLOT)
                    || (r_steps == ffba_pkg::SLOT_BITS'(ffba_pkg::MAX_BLOCKS - 1));

    assign need = {2'b0, r_heap_top} + {2'b0, r_req}
                + (ffba_pkg::ADDR_BITS+2)'(ffba_pkg::HDR_BYTES);
    assign grow_fail = (need > {2'b0, r_heap_limit})
                    || (r_slots_in_use >= ffba_pkg::LINK_BITS'(ffba_pkg::MAX_BLOCKS));
    assign top_hdr = {1'b0, r_heap_top} + (ffba_pkg::ADDR_BITS+1)'(ffba_pkg::HDR_BYTES);

    // Memory port control: walk reads follow the link just fetched.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wrec  = r_rec;
        ram_raddr = rec.link[ffba_pkg::SLOT_BITS-1:0];
        unique case (r_state)
            ST_IDLE: begin
                ram_raddr = in_head[ffba_pkg::SLOT_BITS-1:0];
            end
            ST_CHECK: begin
                if (hit && !r_prev_null) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev;
                    ram_wrec  = '{start: r_prev_rec.start, size: r_prev_rec.size,
                                  link: rec.link};
                end
            end
            ST_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wrec  = '{start: r_rec.start, size: r_rec.size,
                              link: r_is_alloc ? r_used_head : r_free_head};
            end
            ST_GROW: begin
                ram_we    = !grow_fail;
                ram_waddr = r_slots_in_use[ffba_pkg::SLOT_BITS-1:0];
                ram_wrec  = '{start: r_heap_top, size: r_req, link: r_used_head};
            end
            ST_RESP: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffba_ram #(
        .WIDTH (RW),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (RW'(ram_wrec)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_free_head    <= ffba_pkg::NULL_SLOT;
            r_used_head    <= ffba_pkg::NULL_SLOT;
            r_heap_top     <= '0;
            r_slots_in_use <= '0;
            r_heap_limit   <= ffba_pkg::LIMIT_RST;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_limit <= i_cfg_wdata;
            end
            if (r_m_valid && i_m_axis_tready && r_state != ST_RESP) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_beat) begin
                        r_is_alloc  <= (in_kind == ffba_pkg::KIND_ALLOC);
                        r_req       <= in_req;
                        r_addr      <= in_addr;
                        r_cur       <= in_head[ffba_pkg::SLOT_BITS-1:0];
                        r_prev_null <= 1'b1;
                        r_steps     <= '0;
                        r_res_addr  <= '0;
                        r_res_ok    <= 1'b0;
                        unique case (in_kind)
                            ffba_pkg::KIND_ALLOC: begin
                                r_state <= (in_head >= ffba_pkg::NULL_SLOT) ? ST_GROW
                                                                            : ST_CHECK;
                            end
                            ffba_pkg::KIND_FREE: begin
                                if (in_addr != '0 && in_head < ffba_pkg::NULL_SLOT) begin
                                    r_state <= ST_CHECK;
                                end else begin
                                    r_state <= ST_RESP;
                                end
                            end
                            ffba_pkg::KIND_RELEASE: begin
                                r_free_head    <= ffba_pkg::NULL_SLOT;
                                r_used_head    <= ffba_pkg::NULL_SLOT;
                                r_heap_top     <= '0;
                                r_slots_in_use <= '0;
                                r_state        <= ST_RESP;
                            end
                            default: begin
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (hit) begin
                        // Unlink from the walked list: prev record rewritten, or head moved.
                        if (r_prev_null) begin
                            if (r_is_alloc) begin
                                r_free_head <= rec.link;
                            end else begin
                                r_used_head <= rec.link;
                            end
                        end
                        r_rec   <= rec;
                        r_state <= ST_LINK;
                    end else if (walk_end) begin
                        r_state <= r_is_alloc ? ST_GROW : ST_RESP;
                    end else begin
                        r_prev      <= r_cur;
                        r_prev_null <= 1'b0;
                        r_prev_rec  <= rec;
                        r_cur       <= rec.link[ffba_pkg::SLOT_BITS-1:0];
                        r_steps     <= r_steps + 1'b1;
                    end
                end
                ST_LINK: begin
                    if (r_is_alloc) begin
                        r_used_head <= {1'b0, r_cur};
                        r_res_addr  <= start_hdr_of(r_rec.start);
                    end else begin
                        r_free_head <= {1'b0, r_cur};
                    end
                    r_res_ok <= 1'b1;
                    r_state  <= ST_RESP;
                end
                ST_GROW: begin
                    if (!grow_fail) begin
                        r_used_head    <= r_slots_in_use;
                        r_slots_in_use <= r_slots_in_use + 1'b1;
                        r_heap_top     <= need[ffba_pkg::ADDR_BITS-1:0];
                        r_res_addr     <= top_hdr[ffba_pkg::ADDR_BITS-1:0];
                        r_res_ok       <= 1'b1;
                    end
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    // Hold until the output register is free.
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_addr  <= r_res_addr;
                        r_m_ok    <= r_res_ok;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {3'b000, r_m_ok, r_m_addr};

    a_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots_in_use <= ffba_pkg::LINK_BITS'(ffba_pkg::MAX_BLOCKS))
        else $error("slot count above table depth");

    a_beat_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");

    a_null_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_beat && in_kind == ffba_pkg::KIND_FREE && in_addr == '0) |=> (r_state == ST_RESP))
        else $error("null free walked a list");

    a_top_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_GROW && r_state != ST_IDLE) |=> $stable(r_heap_top))
        else $error("heap top changed outside growth or release");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_ok) |-> (r_m_addr == '0))
        else $error("failed result carries an address");

endmodule
